// ===== rtl/core/pfr_pkg.sv =====
// shared types, constants and configuration codes of the polyphase fir resampler
package pfr_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COEF_SHIFT_DEF = 15;
    localparam int RING_DEPTH_DEF = 16384;
    localparam int MAX_TAPS_DEF   = 4096;
    localparam int MAX_PHASES_DEF = 16;

    localparam int COEF_DEPTH = 65536;
    localparam int COEF_AW    = 16;
    localparam int CPO_W      = 24;
    localparam int TC_W       = 12;
    localparam int PL_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int SAMPLE_W   = 16;

    localparam logic [CPO_W-1:0] CPO_RESET = 24'd1427000;
    localparam logic [TC_W-1:0]  TC_RESET  = 12'd2729;
    localparam logic [PL_W-1:0]  PL_RESET  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_OUTPUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT_LOG2  = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_COEF = 1'b1;

    // one output job handed from front to back
    typedef struct packed {
        logic [15:0] ring_base1;
        logic [15:0] ring_base2;
        logic [15:0] coef_base1;
        logic [15:0] coef_base2;
        logic [13:0] taps;
        logic [23:0] weight;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_slot_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LOAD,
        BK_RUN,
        BK_DRAIN,
        BK_MULLO,
        BK_MULHI,
        BK_SCALE,
        BK_FIN,
        BK_OUT
    } back_state_t;

endpackage

// ===== rtl/core/pfr_if.sv =====
// stream interfaces for requests and resampled output
interface pfr_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic signed [15:0] chip_sample;
    logic [15:0] coef_index;
    logic signed [15:0] coef_value;

    modport source (output valid, req_type, chip_sample, coef_index, coef_value, input ready);
    modport sink (input valid, req_type, chip_sample, coef_index, coef_value, output ready);
endinterface

interface pfr_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] out_sample;

    modport source (output valid, out_sample, input ready);
    modport sink (input valid, out_sample, output ready);
endinterface

// ===== rtl/core/pfr_ram.sv =====
// generic single write port ram with registered read
module pfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/pfr_front.sv =====
// front end: config registers, ring and coefficient writes, output scheduling
module pfr_front #(
    parameter int FRAC_BITS  = pfr_pkg::FRAC_BITS_DEF,
    parameter int RING_DEPTH = pfr_pkg::RING_DEPTH_DEF,
    parameter int MAX_TAPS   = pfr_pkg::MAX_TAPS_DEF,
    parameter int MAX_PHASES = pfr_pkg::MAX_PHASES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    pfr_req_if.sink                             req,
    input  logic                                cfg_we,
    input  logic [pfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfr_pkg::CPO_W-1:0]           cfg_data,
    input  logic                                back_busy,
    input  logic                                job_pop,
    output pfr_pkg::job_slot_t                  slot,
    output logic                                ring_we,
    output logic [$clog2(RING_DEPTH)-1:0]       ring_waddr,
    output logic [pfr_pkg::SAMPLE_W-1:0]        ring_wdata,
    output logic                                coef_we,
    output logic [pfr_pkg::COEF_AW-1:0]         coef_waddr,
    output logic [pfr_pkg::SAMPLE_W-1:0]        coef_wdata
);
    localparam int RW       = $clog2(RING_DEPTH);
    localparam int CLW      = pfr_pkg::CPO_W - FRAC_BITS + 2;
    localparam int PHASE_LG = $clog2(MAX_PHASES);
    localparam int TAP_LIM  = (MAX_TAPS < RING_DEPTH - 1) ? MAX_TAPS : RING_DEPTH - 1;

    logic [pfr_pkg::CPO_W-1:0] cpo_reg;
    logic [pfr_pkg::TC_W-1:0]  tc_reg;
    logic [pfr_pkg::PL_W-1:0]  pl_reg;
    logic [RW-1:0]             wpos_reg, wpos_next;
    logic [FRAC_BITS-1:0]      fp_reg, fp_next;
    logic [CLW-1:0]            cl_reg, cl_next;
    logic                      clr_reg;
    logic [RW-1:0]             clr_cnt_reg;
    pfr_pkg::job_slot_t        slot_reg, slot_next;

    logic                      push_acc, coef_acc, due;
    logic [pfr_pkg::CPO_W:0]   sum1, sum2;
    logic [2:0]                lg;
    logic [6:0]                phase1, phase2, phases;
    logic                      back;
    logic [FRAC_BITS-1:0]      weight;
    logic [16:0]               taps_w;
    logic [13:0]               taps;
    logic [RW-1:0]             base1;

    assign req.ready = !clr_reg && !slot_reg.valid && !back_busy;
    assign push_acc  = req.valid && req.ready && (req.req_type == pfr_pkg::REQ_PUSH);
    assign coef_acc  = req.valid && req.ready && (req.req_type == pfr_pkg::REQ_COEF);
    assign due       = (cl_reg <= CLW'(1));

    // phase accumulator and job fields
    always_comb
    begin
        sum1   = {1'b0, {(pfr_pkg::CPO_W - FRAC_BITS){1'b0}}, fp_reg} + {1'b0, cpo_reg};
        fp_next = fp_reg;
        cl_next = cl_reg;
        wpos_next = wpos_reg;
        if (push_acc)
        begin
            wpos_next = wpos_reg + RW'(1);
            if (due)
            begin
                fp_next = sum1[FRAC_BITS-1:0];
            end
        end
        sum2 = {1'b0, {(pfr_pkg::CPO_W - FRAC_BITS){1'b0}}, sum1[FRAC_BITS-1:0]}
               + {1'b0, cpo_reg};
        if (push_acc)
        begin
            if (due)
            begin
                cl_next = CLW'(sum2 >> FRAC_BITS);
            end
            else
            begin
                cl_next = cl_reg - CLW'(1);
            end
        end

        lg     = (pl_reg > 3'(PHASE_LG)) ? 3'(PHASE_LG) : pl_reg;
        phases = 7'd1 << lg;
        phase1 = 7'(sum1[FRAC_BITS-1:0] >> (FRAC_BITS - int'(lg)));
        weight = sum1[FRAC_BITS-1:0] << lg;
        phase2 = phase1 + 7'd1;
        back   = 1'b0;
        if (phase2 >= phases)
        begin
            phase2 = 7'd0;
            back   = 1'b1;
        end

        taps_w = (tc_reg == '0) ? 17'd1 : 17'(tc_reg);
        if (taps_w > 17'(TAP_LIM))
        begin
            taps_w = 17'(TAP_LIM);
        end
        taps  = taps_w[13:0];
        base1 = wpos_next - RW'(taps);

        slot_next = slot_reg;
        if (job_pop)
        begin
            slot_next.valid = 1'b0;
        end
        if (push_acc && due)
        begin
            slot_next.valid          = 1'b1;
            slot_next.job.ring_base1 = 16'(base1);
            slot_next.job.ring_base2 = 16'(base1 - RW'(back));
            slot_next.job.coef_base1 = 16'(phase1) * 16'(taps);
            slot_next.job.coef_base2 = 16'(phase2) * 16'(taps);
            slot_next.job.taps       = taps;
            slot_next.job.weight     = 24'(weight);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpo_reg     <= pfr_pkg::CPO_RESET;
            tc_reg      <= pfr_pkg::TC_RESET;
            pl_reg      <= pfr_pkg::PL_RESET;
            wpos_reg    <= '0;
            fp_reg      <= '0;
            cl_reg      <= CLW'(pfr_pkg::CPO_RESET >> FRAC_BITS);
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            slot_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                priority case (cfg_index)
                    pfr_pkg::CFG_CYCLES_PER_OUTPUT: cpo_reg <= cfg_data;
                    pfr_pkg::CFG_TAP_COUNT:         tc_reg  <= cfg_data[pfr_pkg::TC_W-1:0];
                    pfr_pkg::CFG_PHASE_COUNT_LOG2:  pl_reg  <= cfg_data[pfr_pkg::PL_W-1:0];
                    default: ;
                endcase
            end
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + RW'(1);
                if (clr_cnt_reg == RW'(RING_DEPTH - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            wpos_reg <= wpos_next;
            fp_reg   <= fp_next;
            cl_reg   <= cl_next;
            slot_reg <= slot_next;
        end
    end

    assign slot       = slot_reg;
    assign ring_we    = clr_reg || push_acc;
    assign ring_waddr = clr_reg ? clr_cnt_reg : wpos_reg;
    assign ring_wdata = clr_reg ? '0 : req.chip_sample;
    assign coef_we    = coef_acc;
    assign coef_waddr = req.coef_index;
    assign coef_wdata = req.coef_value;
endmodule

// ===== rtl/core/pfr_back.sv =====
// back end: two-lane mac sweep, phase blend, arithmetic right shift and saturation
module pfr_back #(
    parameter int FRAC_BITS  = pfr_pkg::FRAC_BITS_DEF,
    parameter int COEF_SHIFT = pfr_pkg::COEF_SHIFT_DEF,
    parameter int RING_DEPTH = pfr_pkg::RING_DEPTH_DEF,
    parameter int MAX_TAPS   = pfr_pkg::MAX_TAPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pfr_pkg::job_slot_t                 slot,
    output logic                               job_pop,
    output logic                               busy,
    output logic [$clog2(RING_DEPTH)-1:0]      ring_raddr1,
    output logic [$clog2(RING_DEPTH)-1:0]      ring_raddr2,
    input  logic [pfr_pkg::SAMPLE_W-1:0]       ring_rdata1,
    input  logic [pfr_pkg::SAMPLE_W-1:0]       ring_rdata2,
    output logic [pfr_pkg::COEF_AW-1:0]        coef_raddr1,
    output logic [pfr_pkg::COEF_AW-1:0]        coef_raddr2,
    input  logic [pfr_pkg::SAMPLE_W-1:0]       coef_rdata1,
    input  logic [pfr_pkg::SAMPLE_W-1:0]       coef_rdata2,
    pfr_out_if.source                          rsp
);
    localparam int RW    = $clog2(RING_DEPTH);
    localparam int ACC_W = 32 + $clog2(MAX_TAPS) + 1;
    localparam int DW    = ACC_W + 1;
    localparam int PW    = DW + 26;

    pfr_pkg::back_state_t state_reg, state_next;
    pfr_pkg::job_t        job_reg;
    logic [13:0]          cnt_reg;
    logic                 v0_reg, v1_reg;
    logic signed [31:0]   prod1_reg, prod2_reg;
    logic signed [ACC_W-1:0] acc1_reg, acc2_reg;
    logic [49:0]          plo_reg;
    logic signed [DW-25+24:0] phi_reg;
    logic signed [PW-1:0] scaled_reg;
    logic signed [15:0]   out_reg;

    logic                 issue;
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] pfull, vsum;
    logic signed [15:0]   sat;

    assign diff = DW'(acc2_reg) - DW'(acc1_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfr_pkg::BK_IDLE:  if (slot.valid) state_next = pfr_pkg::BK_LOAD;
            pfr_pkg::BK_LOAD:  state_next = pfr_pkg::BK_RUN;
            pfr_pkg::BK_RUN:   if (cnt_reg == job_reg.taps - 14'd1) state_next = pfr_pkg::BK_DRAIN;
            pfr_pkg::BK_DRAIN: if (!v0_reg && !v1_reg) state_next = pfr_pkg::BK_MULLO;
            pfr_pkg::BK_MULLO: state_next = pfr_pkg::BK_MULHI;
            pfr_pkg::BK_MULHI: state_next = pfr_pkg::BK_SCALE;
            pfr_pkg::BK_SCALE: state_next = pfr_pkg::BK_FIN;
            pfr_pkg::BK_FIN:   state_next = pfr_pkg::BK_OUT;
            pfr_pkg::BK_OUT:   if (rsp.ready) state_next = pfr_pkg::BK_IDLE;
            default:           state_next = pfr_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        issue     = (state_reg == pfr_pkg::BK_RUN);
        job_pop   = (state_reg == pfr_pkg::BK_LOAD);
        busy      = (state_reg != pfr_pkg::BK_IDLE);
        rsp.valid = (state_reg == pfr_pkg::BK_OUT);
    end

    assign ring_raddr1 = job_reg.ring_base1[RW-1:0] + RW'(cnt_reg);
    assign ring_raddr2 = job_reg.ring_base2[RW-1:0] + RW'(cnt_reg);
    assign coef_raddr1 = job_reg.coef_base1 + 16'(cnt_reg);
    assign coef_raddr2 = job_reg.coef_base2 + 16'(cnt_reg);

    always_comb
    begin
        pfull = (PW'(phi_reg) <<< 24) + $signed({{(PW-50){1'b0}}, plo_reg});
        vsum  = (PW'(acc1_reg) + scaled_reg) >>> COEF_SHIFT;
        if (vsum > PW'(32767))
        begin
            sat = 16'sh7fff;
        end
        else if (vsum < -PW'(32768))
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = vsum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfr_pkg::BK_IDLE;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v0_reg    <= issue;
            v1_reg    <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pfr_pkg::BK_IDLE)
        begin
            job_reg <= slot.job;
        end
        if (state_reg == pfr_pkg::BK_LOAD)
        begin
            cnt_reg  <= '0;
            acc1_reg <= '0;
            acc2_reg <= '0;
        end
        if (issue)
        begin
            cnt_reg <= cnt_reg + 14'd1;
        end
        if (v0_reg)
        begin
            prod1_reg <= $signed(ring_rdata1) * $signed(coef_rdata1);
            prod2_reg <= $signed(ring_rdata2) * $signed(coef_rdata2);
        end
        if (v1_reg)
        begin
            acc1_reg <= acc1_reg + ACC_W'(prod1_reg);
            acc2_reg <= acc2_reg + ACC_W'(prod2_reg);
        end
        if (state_reg == pfr_pkg::BK_MULLO)
        begin
            plo_reg <= {1'b0, diff[23:0]} * {1'b0, job_reg.weight};
        end
        if (state_reg == pfr_pkg::BK_MULHI)
        begin
            phi_reg <= $signed(diff[DW-1:24]) * $signed({1'b0, job_reg.weight});
        end
        if (state_reg == pfr_pkg::BK_SCALE)
        begin
            scaled_reg <= pfull >>> FRAC_BITS;
        end
        if (state_reg == pfr_pkg::BK_FIN)
        begin
            out_reg <= sat;
        end
    end

    assign rsp.out_sample = out_reg;
endmodule

// ===== rtl/core/polyphase_fir_resampler.sv =====
// top level of the polyphase fir resampler
//
//  channel  | dir | transaction
//  ---------+-----+----------------------------------------------------
//  req      | in  | push one chip sample or write one coefficient
//  rsp      | out | one resampled sample when an output falls due
//  cfg_*    | in  | register write, taken whenever cfg_we is high
//
// a push with no output due and a coefficient write leave req ready for the next request
// a push that makes an output holds req low while the back end
//   runs both phase sums side by side, one mac per lane per cycle, from the
//   two read ports of the duplicated ring and coefficient rams
// after reset a clearing pass writes zero to every ring entry,
//   req stays low during it
// req stays low while an output job is queued, running or waiting on rsp
module polyphase_fir_resampler #(
    parameter int FRAC_BITS  = pfr_pkg::FRAC_BITS_DEF,
    parameter int COEF_SHIFT = pfr_pkg::COEF_SHIFT_DEF,
    parameter int RING_DEPTH = pfr_pkg::RING_DEPTH_DEF,
    parameter int MAX_TAPS   = pfr_pkg::MAX_TAPS_DEF,
    parameter int MAX_PHASES = pfr_pkg::MAX_PHASES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pfr_req_if.sink                       req,
    pfr_out_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfr_pkg::CPO_W-1:0]     cfg_data
);
    localparam int RW = $clog2(RING_DEPTH);

    pfr_pkg::job_slot_t slot;
    logic               job_pop, back_busy;
    logic               ring_we, coef_we;
    logic [RW-1:0]      ring_waddr, ring_raddr1, ring_raddr2;
    logic [15:0]        ring_wdata, ring_rdata1, ring_rdata2;
    logic [15:0]        coef_waddr, coef_raddr1, coef_raddr2;
    logic [15:0]        coef_wdata, coef_rdata1, coef_rdata2;

    // front end with the one-entry job queue
    pfr_front #(
        .FRAC_BITS  (FRAC_BITS),
        .RING_DEPTH (RING_DEPTH),
        .MAX_TAPS   (MAX_TAPS),
        .MAX_PHASES (MAX_PHASES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .back_busy  (back_busy),
        .job_pop    (job_pop),
        .slot       (slot),
        .ring_we    (ring_we),
        .ring_waddr (ring_waddr),
        .ring_wdata (ring_wdata),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_wdata (coef_wdata)
    );

    // each memory is kept twice so both lanes read in the same cycle
    pfr_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring1 (
        .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
        .raddr(ring_raddr1), .rdata(ring_rdata1)
    );
    pfr_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring2 (
        .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
        .raddr(ring_raddr2), .rdata(ring_rdata2)
    );
    pfr_ram #(.WIDTH(16), .DEPTH(pfr_pkg::COEF_DEPTH)) u_coef1 (
        .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
        .raddr(coef_raddr1), .rdata(coef_rdata1)
    );
    pfr_ram #(.WIDTH(16), .DEPTH(pfr_pkg::COEF_DEPTH)) u_coef2 (
        .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
        .raddr(coef_raddr2), .rdata(coef_rdata2)
    );

    // back end: mac sweep and blend
    pfr_back #(
        .FRAC_BITS  (FRAC_BITS),
        .COEF_SHIFT (COEF_SHIFT),
        .RING_DEPTH (RING_DEPTH),
        .MAX_TAPS   (MAX_TAPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .slot        (slot),
        .job_pop     (job_pop),
        .busy        (back_busy),
        .ring_raddr1 (ring_raddr1),
        .ring_raddr2 (ring_raddr2),
        .ring_rdata1 (ring_rdata1),
        .ring_rdata2 (ring_rdata2),
        .coef_raddr1 (coef_raddr1),
        .coef_raddr2 (coef_raddr2),
        .coef_rdata1 (coef_rdata1),
        .coef_rdata2 (coef_rdata2),
        .rsp         (rsp)
    );

    // no new request while a result is on offer
    a_no_req_with_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request accepted while result pending");

    // a job is only popped when one was queued
    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> slot.valid)
        else $error("job popped from empty queue");

    // an accepted request never shows a result in the next cycle
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !rsp.valid)
        else $error("result appeared too early");
endmodule

// ===== test/tb_top.sv =====
// self-checking testbench of the polyphase fir resampler
`timescale 1ns / 1ps

module tb_top;

    localparam int RING_N     = pfr_pkg::RING_DEPTH_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int SET_COUNT  = 9;
    localparam int COEF_FILL  = 256;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pfr_pkg::CPO_W-1:0] cfg_data;

    pfr_req_if req_ch ();
    pfr_out_if rsp_ch ();

    polyphase_fir_resampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // shadow state of the resampler
    logic signed [15:0] ring_mem [0:RING_N-1];
    logic signed [15:0] coef_mem [0:pfr_pkg::COEF_DEPTH-1];
    int unsigned        ring_wr;
    logic [15:0]        frac_acc;
    int unsigned        cycles_to_go;
    logic [pfr_pkg::CPO_W-1:0] rate_reg;
    logic [pfr_pkg::TC_W-1:0]  taps_reg;
    logic [pfr_pkg::PL_W-1:0]  plog_reg;

    // samples still owed by the block, oldest first
    logic signed [15:0] owed_samples [$];

    int  mismatches = 0;
    int  outputs_seen = 0;
    int  clock_ticks = 0;
    bit  idle_on = 1'b0;

    // one fir sum over the newest taps, optionally one sample older
    function automatic longint phase_sum(int unsigned ph, int unsigned taps,
                                         int unsigned older);
        longint      acc;
        int unsigned base;
        acc = 0;
        base = ring_wr + 2 * RING_N - taps - older;
        for (int unsigned j = 0; j < taps; j++)
        begin
            acc += longint'(ring_mem[(base + j) % RING_N])
                 * longint'(coef_mem[(ph * taps + j) & 32'hffff]);
        end
        return acc;
    endfunction

    // blend of two adjacent phases, shifted and saturated
    function automatic logic signed [15:0] blended_sample();
        int unsigned taps;
        int unsigned phases;
        int unsigned scaled;
        int unsigned ph;
        int unsigned weight;
        int unsigned older;
        longint      v1;
        longint      v2;
        longint      v;
        taps = (taps_reg == 0) ? 1 : int'(taps_reg);
        if (taps > pfr_pkg::MAX_TAPS_DEF)
            taps = pfr_pkg::MAX_TAPS_DEF;
        if (taps > RING_N - 1)
            taps = RING_N - 1;
        phases = 1 << plog_reg;
        if (phases > pfr_pkg::MAX_PHASES_DEF)
            phases = pfr_pkg::MAX_PHASES_DEF;
        scaled = int'(frac_acc) * phases;
        ph = scaled >> 16;
        weight = scaled & 32'hffff;
        older = 0;
        v1 = phase_sum(ph, taps, 0);
        ph++;
        // past the last phase: phase 0, one sample older
        if (ph >= phases)
        begin
            ph = 0;
            older = 1;
        end
        v2 = phase_sum(ph, taps, older);
        v = v1 + (((v2 - v1) * longint'(weight)) >>> 16);
        v = v >>> pfr_pkg::COEF_SHIFT_DEF;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // advance the shadow state by one accepted request
    task automatic model_request(input logic kind, input logic signed [15:0] smp,
                                 input logic [15:0] idx, input logic signed [15:0] val,
                                 output bit due, output logic signed [15:0] y);
        logic [24:0] sum;
        due = 1'b0;
        y = '0;
        if (kind == pfr_pkg::REQ_COEF)
        begin
            coef_mem[idx] = val;
            return;
        end
        ring_mem[ring_wr] = smp;
        ring_wr = (ring_wr + 1) % RING_N;
        if (cycles_to_go > 1)
        begin
            cycles_to_go--;
            return;
        end
        sum = {9'd0, frac_acc} + {1'b0, rate_reg};
        frac_acc = sum[15:0];
        y = blended_sample();
        due = 1'b1;
        sum = {9'd0, frac_acc} + {1'b0, rate_reg};
        cycles_to_go = int'(sum >> 16);
    endtask

    task automatic write_reg(input logic [pfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pfr_pkg::CPO_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            pfr_pkg::CFG_CYCLES_PER_OUTPUT: rate_reg = val;
            pfr_pkg::CFG_TAP_COUNT:         taps_reg = val[pfr_pkg::TC_W-1:0];
            pfr_pkg::CFG_PHASE_COUNT_LOG2:  plog_reg = val[pfr_pkg::PL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // registers only change once the block has gone quiet
    task automatic set_rates(input logic [pfr_pkg::CPO_W-1:0] rate,
                             input logic [pfr_pkg::TC_W-1:0] taps,
                             input logic [pfr_pkg::PL_W-1:0] plog);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (owed_samples.size() != 0)
            @(posedge clk);
        repeat (int'(taps_reg) + 32) @(posedge clk);
        write_reg(pfr_pkg::CFG_CYCLES_PER_OUTPUT, rate);
        write_reg(pfr_pkg::CFG_TAP_COUNT, 24'(taps));
        write_reg(pfr_pkg::CFG_PHASE_COUNT_LOG2, 24'(plog));
    endtask

    // one request transaction; valid stays high into the next call
    task automatic send_request(input logic kind, input logic signed [15:0] smp,
                                input logic [15:0] idx, input logic signed [15:0] val,
                                input bit fixed, input logic signed [15:0] fixed_val);
        bit                 due;
        logic signed [15:0] y;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.chip_sample <= smp;
        req_ch.coef_index <= idx;
        req_ch.coef_value <= val;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
                break;
        end
        model_request(kind, smp, idx, val, due, y);
        if (due)
            owed_samples.push_back(fixed ? fixed_val : y);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // directed rows: one phase, one tap, output due on every push
    typedef struct {
        logic               kind;
        logic signed [15:0] smp;
        logic [15:0]        idx;
        logic signed [15:0] val;
        bit                 fixed;
        logic signed [15:0] fixed_val;
    } stim_row_t;

    stim_row_t directed_rows [12] = '{
        '{pfr_pkg::REQ_COEF, 16'sd0,     16'd0,     16'sh7fff, 1'b0, 16'sd0},
        '{pfr_pkg::REQ_PUSH, 16'sh7fff,  16'd0,     16'sd0,    1'b1, 16'sd32766},
        '{pfr_pkg::REQ_PUSH, 16'sh8000,  16'd0,     16'sd0,    1'b1, -16'sd32767},
        '{pfr_pkg::REQ_PUSH, 16'sd0,     16'd0,     16'sd0,    1'b1, 16'sd0},
        '{pfr_pkg::REQ_COEF, 16'sd0,     16'd0,     16'sh8000, 1'b0, 16'sd0},
        '{pfr_pkg::REQ_PUSH, 16'sh8000,  16'd0,     16'sd0,    1'b1, 16'sd32767},
        '{pfr_pkg::REQ_PUSH, 16'sh7fff,  16'd0,     16'sd0,    1'b1, -16'sd32767},
        '{pfr_pkg::REQ_PUSH, 16'sd1,     16'd0,     16'sd0,    1'b1, -16'sd1},
        '{pfr_pkg::REQ_PUSH, -16'sd1,    16'd0,     16'sd0,    1'b1, 16'sd1},
        '{pfr_pkg::REQ_COEF, 16'sd0,     16'hffff,  16'sh5a5a, 1'b0, 16'sd0},
        '{pfr_pkg::REQ_COEF, 16'sd0,     16'd1,     16'sh4000, 1'b0, 16'sd0},
        '{pfr_pkg::REQ_PUSH, 16'sh1234,  16'd0,     16'sd0,    1'b0, 16'sd0}
    };

    // rate settings: rate, taps, log2 phases, request count
    typedef struct {
        logic [pfr_pkg::CPO_W-1:0] rate;
        logic [pfr_pkg::TC_W-1:0]  taps;
        logic [pfr_pkg::PL_W-1:0]  plog;
        int                        count;
    } rate_set_t;

    rate_set_t rate_sets [SET_COUNT];

    // response side: random stall bursts
    initial
    begin
        int hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 11) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // compare every output transaction with the oldest owed sample
    always @(posedge clk)
    begin
        logic signed [15:0] want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            outputs_seen++;
            if (owed_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output %0d", rsp_ch.out_sample);
            end
            else
            begin
                want = owed_samples.pop_front();
                if (rsp_ch.out_sample !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("out_sample: expected %0d, got %0d", want,
                                 rsp_ch.out_sample);
                end
            end
        end
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        clock_ticks++;
        if (clock_ticks > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", clock_ticks);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = pfr_pkg::REQ_PUSH;
        req_ch.chip_sample = '0;
        req_ch.coef_index = '0;
        req_ch.coef_value = '0;

        for (int i = 0; i < RING_N; i++)
            ring_mem[i] = '0;
        ring_wr = 0;
        frac_acc = '0;
        rate_reg = pfr_pkg::CPO_RESET;
        taps_reg = pfr_pkg::TC_RESET;
        plog_reg = pfr_pkg::PL_RESET;
        cycles_to_go = int'(pfr_pkg::CPO_RESET >> 16);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every setting below reads at most phases * taps <= COEF_FILL entries
        for (int i = 0; i < COEF_FILL; i++)
            send_request(pfr_pkg::REQ_COEF, 16'sd0, i[15:0], 16'($urandom()), 1'b0, 16'sd0);

        // every push due, single tap, single phase
        set_rates(24'd0, 12'd1, 3'd0);
        // run down the countdown left from the reset rate
        while (cycles_to_go != 0)
            send_request(pfr_pkg::REQ_PUSH, 16'sd0, 16'd0, 16'sd0, 1'b0, 16'sd0);
        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].smp,
                         directed_rows[i].idx, directed_rows[i].val,
                         directed_rows[i].fixed, directed_rows[i].fixed_val);

        // fixed corners first, then random small filters
        rate_sets[0] = '{pfr_pkg::CPO_RESET, 12'd9, pfr_pkg::PL_RESET, 100};
        rate_sets[1] = '{24'd0, 12'd0, 3'd0, 150};
        rate_sets[2] = '{24'd65536, 12'd12, 3'd7, 60};
        rate_sets[3] = '{24'hffffff, 12'd2, 3'd5, 300};
        for (int s = 4; s < SET_COUNT; s++)
            rate_sets[s] = '{24'($urandom_range(0, 8 << 16)), 12'($urandom_range(1, 16)),
                             3'($urandom_range(0, 7)), 120};

        idle_on = 1'b1;
        for (int s = 0; s < SET_COUNT; s++)
        begin
            set_rates(rate_sets[s].rate, rate_sets[s].taps, rate_sets[s].plog);
            // final setting runs with both sides at full speed
            if (s == SET_COUNT - 1)
                idle_on = 1'b0;
            for (int n = 0; n < rate_sets[s].count; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(pfr_pkg::REQ_COEF, 16'sd0, 16'($urandom()),
                                 16'($urandom()), 1'b0, 16'sd0);
                else
                    send_request(pfr_pkg::REQ_PUSH, pick_sample(), 16'($urandom()),
                                 16'($urandom()), 1'b0, 16'sd0);
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (owed_samples.size() != 0)
            @(posedge clk);
        repeat (int'(taps_reg) + 64) @(posedge clk);

        $display("covered %0d rate settings plus directed corners, %0d outputs checked",
                 SET_COUNT, outputs_seen);
        $display("mismatch count %0d", mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
